### rtl/lcats_pkg.sv
// shared constants, types and command formats of the load cell average, tare and scale block
package lcats_pkg;

  localparam int unsigned SAMPLES_PER_READING_DEF = 8;
  localparam int unsigned CHANNELS_DEF            = 2;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned SUM_W      = 31;
  localparam int unsigned SCALE_W    = 32;
  localparam int unsigned GRAMS_W    = 40;
  localparam int unsigned FRAC_W     = 32;
  localparam int unsigned DIFF_W     = SAMPLE_W + 1;
  localparam int unsigned DVD_W      = DIFF_W + FRAC_W;
  localparam int unsigned STEP_W     = $clog2(DVD_W + 1);
  localparam int unsigned AVG_MAG_W  = SUM_W - 1;
  localparam int unsigned AVG_PROD_W = AVG_MAG_W + SUM_W;
  localparam int unsigned NUM_SCALE  = 2;
  localparam int unsigned NUM_OFF    = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned Q_DEPTH    = 2;

  localparam logic [STEP_W-1:0]  WGT_STEPS   = STEP_W'(DVD_W);
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;
  localparam logic [DVD_W-1:0]   FLOOR_MAG   = DVD_W'(327680);
  localparam logic signed [GRAMS_W-1:0] GRAMS_MAX = {1'b0, {(GRAMS_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {REG_SCALE0, REG_SCALE1} reg_idx_e;
  typedef enum logic {CMD_TIMEOUT, CMD_RUN} cmd_kind_e;
  typedef enum logic {MODE_WEIGH, MODE_TARE} mode_e;
  typedef enum logic {ST_OK, ST_TIMEOUT} status_e;
  typedef enum logic {KIND_WEIGHT, KIND_TARE} kind_e;

  typedef struct packed {
    cmd_kind_e               kind;
    mode_e                   mode;
    logic                    channel;
    logic signed [SUM_W-1:0] sum;
  } cmd_t;

  typedef struct packed {
    logic                start;
    logic [STEP_W-1:0]   steps;
    logic [DVD_W-1:0]    dividend;
    logic [SCALE_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef logic [NUM_SCALE-1:0][SCALE_W-1:0] scale_arr_t;

endpackage

### rtl/lcats_if.sv
// request and result channel interfaces
interface lcats_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  channel;
  logic                                  mode;
  logic signed [lcats_pkg::SAMPLE_W-1:0] sample;
  logic                                  not_ready;

  modport source (output valid, channel, mode, sample, not_ready, input ready);
  modport sink (input valid, channel, mode, sample, not_ready, output ready);
endinterface

interface lcats_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 status;
  logic                                 kind;
  logic signed [lcats_pkg::GRAMS_W-1:0] grams;
  logic                                 result_channel;

  modport source (output valid, status, kind, grams, result_channel, input ready);
  modport sink (input valid, status, kind, grams, result_channel, output ready);
endinterface

### rtl/lcats_front.sv
// front end: accepts samples, accumulates runs and issues commands
module lcats_front #(
  parameter int unsigned SAMPLES_PER_READING = lcats_pkg::SAMPLES_PER_READING_DEF,
  parameter int unsigned CHANNELS            = lcats_pkg::CHANNELS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  lcats_in_if.sink        in_if,
  input  logic            full_i,
  output logic            push_o,
  output lcats_pkg::cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_READING + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

  logic [CNT_W-1:0]                   cnt_q;
  logic signed [lcats_pkg::SUM_W-1:0] sum_q;
  logic signed [lcats_pkg::SUM_W-1:0] sum_add;
  logic                               accept;
  logic                               in_range;
  logic                               run_end;

  assign in_if.ready = !full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign in_range    = 32'(in_if.channel) < CHANNELS;
  assign sum_add     = sum_q + lcats_pkg::SUM_W'(in_if.sample);
  assign run_end     = in_if.not_ready || (cnt_q == CNT_LAST);
  assign push_o      = accept && in_range && run_end;

  assign cmd_o.kind    = in_if.not_ready ? lcats_pkg::CMD_TIMEOUT : lcats_pkg::CMD_RUN;
  assign cmd_o.mode    = lcats_pkg::mode_e'(in_if.mode);
  assign cmd_o.channel = in_if.channel;
  assign cmd_o.sum     = sum_add;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else if (accept && in_range) begin
      if (run_end) begin
        cnt_q <= '0;
        sum_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_add;
      end
    end
  end

endmodule

### rtl/lcats_fifo.sv
// short command queue between front and back end
module lcats_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcats_pkg::cmd_t wdata_i,
  input  logic            pop_i,
  output lcats_pkg::cmd_t head_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PTR_W = $clog2(lcats_pkg::Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(lcats_pkg::Q_DEPTH + 1);

  lcats_pkg::cmd_t  mem_q [lcats_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign full_o  = cnt_q == CNT_W'(lcats_pkg::Q_DEPTH);
  assign empty_o = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(lcats_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(lcats_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

### rtl/lcats_div.sv
// restoring divider, one quotient bit per cycle
module lcats_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcats_pkg::div_req_t req_i,
  output lcats_pkg::div_rsp_t rsp_o
);

  logic [lcats_pkg::SCALE_W-1:0] dvs_q;
  logic [lcats_pkg::SCALE_W-1:0] rem_q;
  logic [lcats_pkg::DVD_W-1:0]   dq_q;
  logic [lcats_pkg::STEP_W-1:0]  cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [lcats_pkg::SCALE_W:0]   shifted;
  logic [lcats_pkg::SCALE_W:0]   diff;
  logic                          qbit;

  assign shifted = {rem_q, dq_q[lcats_pkg::DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign qbit    = !diff[lcats_pkg::SCALE_W];

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvs_q  <= '0;
      rem_q  <= '0;
      dq_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        dvs_q  <= req_i.divisor;
        rem_q  <= '0;
        dq_q   <= req_i.dividend;
        cnt_q  <= req_i.steps;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= qbit ? diff[lcats_pkg::SCALE_W-1:0] : shifted[lcats_pkg::SCALE_W-1:0];
        dq_q  <= {dq_q[lcats_pkg::DVD_W-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == lcats_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

### rtl/lcats_back.sv
// back end: averages runs, stores tare offsets, scales weights and drives results
module lcats_back #(
  parameter int unsigned SAMPLES_PER_READING = lcats_pkg::SAMPLES_PER_READING_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  lcats_pkg::cmd_t       head_i,
  output logic                  pop_o,
  input  lcats_pkg::scale_arr_t scale_i,
  output lcats_pkg::div_req_t   div_req_o,
  input  lcats_pkg::div_rsp_t   div_rsp_i,
  lcats_out_if.source           out_if
);

  localparam int unsigned SW = lcats_pkg::SAMPLE_W;
  localparam int unsigned DW = lcats_pkg::DIFF_W;
  localparam int unsigned GW = lcats_pkg::GRAMS_W;
  localparam int unsigned QW = lcats_pkg::DVD_W;
  localparam int unsigned MW = lcats_pkg::AVG_MAG_W;
  localparam int unsigned PW = lcats_pkg::AVG_PROD_W;
  localparam int unsigned AVG_SHIFT = MW + $clog2(SAMPLES_PER_READING);
  localparam logic [lcats_pkg::SUM_W-1:0] AVG_RECIP = lcats_pkg::SUM_W'(
    ((64'd1 << AVG_SHIFT) + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING));

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_AVG, S_WGT, S_EMIT} state_e;

  state_e                              state_q;
  lcats_pkg::cmd_t                     cmd_q;
  logic signed [SW-1:0]                offset_q [lcats_pkg::NUM_OFF];
  logic                                neg_q;
  logic [MW-1:0]                       sum_mag_q;
  logic [PW-1:0]                       prod_q;
  lcats_pkg::div_req_t                 req_q;
  lcats_pkg::status_e                  res_status_q;
  lcats_pkg::kind_e                    res_kind_q;
  logic signed [GW-1:0]                res_grams_q;
  logic                                res_ch_q;
  logic                                ovalid_q;
  lcats_pkg::status_e                  out_status_q;
  lcats_pkg::kind_e                    out_kind_q;
  logic signed [GW-1:0]                out_grams_q;
  logic                                out_ch_q;

  logic [MW-1:0]                       sum_mag;
  logic [SW-1:0]                       avg_mag;
  logic signed [DW-1:0]                avg_full;
  logic signed [SW-1:0]                avg;
  logic signed [DW-1:0]                diff;
  logic [DW-1:0]                       diff_mag;
  logic [QW-1:0]                       q;
  logic signed [GW-1:0]                grams_sat;
  logic                                emit;

  assign pop_o     = (state_q == S_IDLE) && !empty_i;
  assign div_req_o = req_q;

  // average by reciprocal multiplication, exact for every run sum magnitude
  assign sum_mag  = head_i.sum[lcats_pkg::SUM_W-1] ? MW'(-head_i.sum) : MW'(head_i.sum);
  assign avg_mag  = prod_q[AVG_SHIFT +: SW];
  assign q        = div_rsp_i.quotient;
  assign avg_full = neg_q ? -$signed({1'b0, avg_mag}) : $signed({1'b0, avg_mag});
  assign avg      = avg_full[SW-1:0];
  assign diff     = DW'(avg) - DW'(offset_q[cmd_q.channel]);
  assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign emit     = (state_q == S_EMIT) && (!ovalid_q || out_if.ready);

  always_comb begin
    if (neg_q) begin
      grams_sat = (q > lcats_pkg::FLOOR_MAG) ? '0 : -$signed(q[GW-1:0]);
    end else if (|q[QW-1:GW-1]) begin
      grams_sat = lcats_pkg::GRAMS_MAX;
    end else begin
      grams_sat = $signed(q[GW-1:0]);
    end
  end

  assign out_if.valid          = ovalid_q;
  assign out_if.status         = out_status_q;
  assign out_if.kind           = out_kind_q;
  assign out_if.grams          = out_grams_q;
  assign out_if.result_channel = out_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      offset_q     <= '{default: '0};
      neg_q        <= 1'b0;
      sum_mag_q    <= '0;
      prod_q       <= '0;
      req_q        <= '0;
      res_status_q <= lcats_pkg::ST_OK;
      res_kind_q   <= lcats_pkg::KIND_WEIGHT;
      res_grams_q  <= '0;
      res_ch_q     <= 1'b0;
      ovalid_q     <= 1'b0;
      out_status_q <= lcats_pkg::ST_OK;
      out_kind_q   <= lcats_pkg::KIND_WEIGHT;
      out_grams_q  <= '0;
      out_ch_q     <= 1'b0;
    end else begin
      req_q.start <= (state_q == S_AVG) && (cmd_q.mode == lcats_pkg::MODE_WEIGH);
      if (emit) begin
        ovalid_q     <= 1'b1;
        out_status_q <= res_status_q;
        out_kind_q   <= res_kind_q;
        out_grams_q  <= res_grams_q;
        out_ch_q     <= res_ch_q;
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cmd_q    <= head_i;
            res_ch_q <= head_i.channel;
            if (head_i.kind == lcats_pkg::CMD_TIMEOUT) begin
              res_status_q <= lcats_pkg::ST_TIMEOUT;
              res_kind_q   <= lcats_pkg::KIND_WEIGHT;
              res_grams_q  <= '0;
              state_q      <= S_EMIT;
            end else begin
              sum_mag_q <= sum_mag;
              neg_q     <= head_i.sum[lcats_pkg::SUM_W-1];
              state_q   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= PW'(sum_mag_q) * PW'(AVG_RECIP);
          state_q <= S_AVG;
        end
        S_AVG: begin
          res_status_q <= lcats_pkg::ST_OK;
          if (cmd_q.mode == lcats_pkg::MODE_TARE) begin
            offset_q[cmd_q.channel] <= avg;
            res_kind_q              <= lcats_pkg::KIND_TARE;
            res_grams_q             <= '0;
            state_q                 <= S_EMIT;
          end else begin
            req_q.steps    <= lcats_pkg::WGT_STEPS;
            req_q.dividend <= {diff_mag, lcats_pkg::FRAC_W'(0)};
            req_q.divisor  <= scale_i[cmd_q.channel];
            neg_q          <= diff[DW-1];
            state_q        <= S_WGT;
          end
        end
        S_WGT: begin
          if (div_rsp_i.done) begin
            res_kind_q  <= lcats_pkg::KIND_WEIGHT;
            res_grams_q <= grams_sat;
            state_q     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == S_WGT))
    else $error("divider result arrived with no division pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !div_rsp_i.busy)
    else $error("result emitted while divider still running");

endmodule

### rtl/load_cell_average_tare_scale.sv
// Load-cell average, tare and scale block. Samples enter on in_if; every sample that does not
// end a run is taken while the queue has room. A run-ending request, or a timeout, is queued
// (two entries) for the back end. A timeout result goes from S_IDLE straight to S_EMIT; a tare
// passes S_MUL and S_AVG, and a weight then waits in S_WGT for the divider. The average is a
// constant reciprocal multiplication, registered in S_MUL; a weight is scaled by the
// one-bit-per-cycle scale divider (57 steps). The back end takes the next queued request in
// the cycle after a result is registered, and it stalls while a result waits on out_if; the
// front end keeps accepting samples while the queue has room. Scale registers are written on
// the cfg port; zero values are ignored.
module load_cell_average_tare_scale #(
  parameter int unsigned SAMPLES_PER_READING = lcats_pkg::SAMPLES_PER_READING_DEF,
  parameter int unsigned CHANNELS            = lcats_pkg::CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lcats_in_if.sink                        in_if,
  lcats_out_if.source                     out_if,
  input  logic                            cfg_we_i,
  input  logic [lcats_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lcats_pkg::SCALE_W-1:0]   cfg_data_i
);

  lcats_pkg::scale_arr_t scale_q;
  lcats_pkg::cmd_t       push_cmd;
  lcats_pkg::cmd_t       head;
  lcats_pkg::div_req_t   div_req;
  lcats_pkg::div_rsp_t   div_rsp;
  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= {lcats_pkg::NUM_SCALE{lcats_pkg::SCALE_RESET}};
    end else if (cfg_we_i && (cfg_data_i != '0)) begin
      case (lcats_pkg::reg_idx_e'(cfg_idx_i))
        lcats_pkg::REG_SCALE0: scale_q[0] <= cfg_data_i;
        lcats_pkg::REG_SCALE1: scale_q[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lcats_front #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING),
    .CHANNELS           (CHANNELS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .full_i(full),
    .push_o(push),
    .cmd_o (push_cmd)
  );

  lcats_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_cmd),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full),
    .empty_o(empty)
  );

  lcats_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  lcats_back #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (head),
    .pop_o    (pop),
    .scale_i  (scale_q),
    .div_req_o(div_req),
    .div_rsp_i(div_rsp),
    .out_if   (out_if)
  );

endmodule
